FILE: sv/ksc_pkg.sv
// Shared constants, codes and the quadrature step table of the key and knob event scanner.
package ksc_pkg;

  localparam int KEY_LEVEL_W = 6;
  localparam int SLOT_W      = 4;
  localparam int ACT_W       = 3;
  localparam int CNT_W       = 8;
  localparam int ACC_W       = 8;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [ACT_W-1:0]  action_t;
  typedef logic [CNT_W-1:0]  count_t;
  typedef logic [ACC_W-1:0]  accum_t;
  typedef logic [1:0]        quad_t;

  localparam count_t LOCKOUT_RESET = 8'd10;
  localparam quad_t  QUAD_REST     = 2'd3;

  localparam slot_t SLOT_CCW      = 4'd6;
  localparam slot_t SLOT_CLICK    = 4'd7;
  localparam slot_t SLOT_CW       = 4'd8;
  localparam slot_t SLOT_PUSH_CCW = 4'd9;
  localparam slot_t SLOT_PUSH_CW  = 4'd10;

  localparam action_t ACT_DOWN     = 3'd0;
  localparam action_t ACT_UP       = 3'd1;
  localparam action_t ACT_CW       = 3'd2;
  localparam action_t ACT_CCW      = 3'd3;
  localparam action_t ACT_CLICK    = 3'd4;
  localparam action_t ACT_PUSH_CW  = 3'd5;
  localparam action_t ACT_PUSH_CCW = 3'd6;

  // Signed step for a transition from the previous to the current quadrature state.
  function automatic accum_t step_delta(input logic [3:0] idx);
    accum_t d;
    d = '0;
    unique case (idx)
      4'd1, 4'd7, 4'd8, 4'd14: d = 8'hFF;
      4'd2, 4'd4, 4'd11, 4'd13: d = 8'h01;
      default: d = '0;
    endcase
    return d;
  endfunction

  // Slot that belongs to an encoder action.
  function automatic slot_t enc_slot(input action_t act);
    slot_t s;
    s = SLOT_CCW;
    unique case (act)
      ACT_CW:       s = SLOT_CW;
      ACT_PUSH_CW:  s = SLOT_PUSH_CW;
      ACT_PUSH_CCW: s = SLOT_PUSH_CCW;
      default:      s = SLOT_CCW;
    endcase
    return s;
  endfunction

endpackage

FILE: sv/ksc_ifs.sv
// Valid/ready channel interfaces for scan samples and events.
interface ksc_sample_if;
  logic       valid;
  logic       ready;
  logic [5:0] key_levels;
  logic       knob_switch_level;
  logic       quad_a;
  logic       quad_b;

  modport source (output valid, key_levels, knob_switch_level, quad_a, quad_b, input ready);
  modport sink (input valid, key_levels, knob_switch_level, quad_a, quad_b, output ready);
endinterface

interface ksc_event_if;
  logic       valid;
  logic       ready;
  logic [3:0] event_slot;
  logic [2:0] event_action;
  logic       event_value;
  logic       last_of_pass;

  modport source (output valid, event_slot, event_action, event_value, last_of_pass,
                  input ready);
  modport sink (input valid, event_slot, event_action, event_value, last_of_pass,
                output ready);
endinterface

FILE: sv/ksc_front.sv
// Front end: debounces keys and switch, decodes the encoder, records passes with events.
module ksc_front #(
  parameter int NUM_KEYS = 6
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic [5:0]            key_levels,
  input  logic                  knob_switch_level,
  input  logic                  quad_a,
  input  logic                  quad_b,
  input  ksc_pkg::count_t       lockout_passes,
  output logic                  push,
  output logic [NUM_KEYS-1:0]   key_evt,
  output logic [NUM_KEYS-1:0]   key_up,
  output logic                  click,
  output logic                  enc_evt,
  output ksc_pkg::action_t      enc_act
);

  logic [NUM_KEYS-1:0]   key_state;
  logic [NUM_KEYS-1:0]   key_state_next;
  ksc_pkg::count_t       key_lock [NUM_KEYS];
  ksc_pkg::count_t       key_lock_next [NUM_KEYS];
  ksc_pkg::count_t       sw_lock;
  ksc_pkg::count_t       sw_lock_next;
  logic                  switch_held;
  logic                  switch_held_next;
  logic                  turned;
  logic                  turned_next;
  ksc_pkg::quad_t        prev_quad;
  ksc_pkg::quad_t        prev_quad_next;
  ksc_pkg::accum_t       acc;
  ksc_pkg::accum_t       acc_next;

  logic [ksc_pkg::KEY_LEVEL_W+NUM_KEYS-1:0] levels_pad;
  logic [NUM_KEYS-1:0]   now_lv;
  ksc_pkg::quad_t        ab;
  ksc_pkg::accum_t       sum;

  always_comb begin
    levels_pad = {{NUM_KEYS{1'b0}}, key_levels};
    now_lv     = levels_pad[NUM_KEYS-1:0];
    key_state_next = key_state;
    key_evt = '0;
    key_up  = '0;
    for (int i = 0; i < NUM_KEYS; i++) begin
      key_lock_next[i] = key_lock[i];
      if (key_lock[i] != '0) begin
        key_lock_next[i] = key_lock[i] - 8'd1;
      end else if (now_lv[i] != key_state[i]) begin
        key_lock_next[i]  = lockout_passes;
        key_evt[i]        = 1'b1;
        key_up[i]         = now_lv[i];
        key_state_next[i] = now_lv[i];
      end
    end

    sw_lock_next     = sw_lock;
    switch_held_next = switch_held;
    turned_next      = turned;
    click            = 1'b0;
    if (sw_lock != '0) begin
      sw_lock_next = sw_lock - 8'd1;
    end else if (!knob_switch_level && !switch_held) begin
      switch_held_next = 1'b1;
      turned_next      = 1'b0;
      sw_lock_next     = lockout_passes;
    end else if (knob_switch_level && switch_held) begin
      switch_held_next = 1'b0;
      sw_lock_next     = lockout_passes;
      click            = !turned;
    end

    ab             = {quad_a, quad_b};
    sum            = acc + ksc_pkg::step_delta({prev_quad, ab});
    prev_quad_next = prev_quad;
    acc_next       = acc;
    enc_evt        = 1'b0;
    enc_act        = ksc_pkg::ACT_CW;
    if (ab != prev_quad) begin
      prev_quad_next = ab;
      acc_next       = sum;
      if (ab == ksc_pkg::QUAD_REST && sum != '0) begin
        enc_evt  = 1'b1;
        acc_next = '0;
        if (switch_held_next) begin
          turned_next = 1'b1;
          enc_act     = sum[ksc_pkg::ACC_W-1] ? ksc_pkg::ACT_PUSH_CCW : ksc_pkg::ACT_PUSH_CW;
        end else begin
          enc_act     = sum[ksc_pkg::ACC_W-1] ? ksc_pkg::ACT_CCW : ksc_pkg::ACT_CW;
        end
      end
    end

    push = accept && ((|key_evt) || click || enc_evt);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_state   <= '1;
      sw_lock     <= '0;
      switch_held <= 1'b0;
      turned      <= 1'b0;
      prev_quad   <= ksc_pkg::QUAD_REST;
      acc         <= '0;
      for (int i = 0; i < NUM_KEYS; i++) begin
        key_lock[i] <= '0;
      end
    end else if (accept) begin
      key_state   <= key_state_next;
      sw_lock     <= sw_lock_next;
      switch_held <= switch_held_next;
      turned      <= turned_next;
      prev_quad   <= prev_quad_next;
      acc         <= acc_next;
      for (int i = 0; i < NUM_KEYS; i++) begin
        key_lock[i] <= key_lock_next[i];
      end
    end
  end

endmodule

FILE: sv/ksc_queue.sv
// Small register queue that holds pass records between front and back end.
module ksc_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: sv/ksc_back.sv
// Back end: serializes the events of each pass record onto the event channel.
module ksc_back #(
  parameter int NUM_KEYS = 6
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                rec_avail,
  input  logic [NUM_KEYS-1:0] rec_key_evt,
  input  logic [NUM_KEYS-1:0] rec_key_up,
  input  logic                rec_click,
  input  logic                rec_enc_evt,
  input  ksc_pkg::action_t    rec_enc_act,
  output logic                rec_pop,
  ksc_event_if.source         events
);

  localparam int EV_N = NUM_KEYS + 2;

  logic [EV_N-1:0]     cur_mask;
  logic [NUM_KEYS-1:0] cur_up;
  ksc_pkg::action_t    cur_act;

  logic [EV_N-1:0]     first;
  logic [EV_N-1:0]     rem;
  logic                cur_valid;
  logic                advance;
  logic                emit;
  logic                is_up;
  ksc_pkg::slot_t      key_slot;
  ksc_pkg::slot_t      ev_slot;
  ksc_pkg::action_t    ev_act;

  always_comb begin
    cur_valid = |cur_mask;
    first     = cur_mask & (~cur_mask + 1'b1);
    rem       = cur_mask & ~first;
    advance   = !events.valid || events.ready;
    emit      = advance && cur_valid;
    rec_pop   = rec_avail && (!cur_valid || (emit && rem == '0));

    key_slot = '0;
    for (int i = 0; i < NUM_KEYS; i++) begin
      if (first[i]) begin
        key_slot = key_slot | ksc_pkg::SLOT_W'(i);
      end
    end
    is_up = |(first[NUM_KEYS-1:0] & cur_up);

    if (first[NUM_KEYS+1]) begin
      ev_slot = ksc_pkg::enc_slot(cur_act);
      ev_act  = cur_act;
    end else if (first[NUM_KEYS]) begin
      ev_slot = ksc_pkg::SLOT_CLICK;
      ev_act  = ksc_pkg::ACT_CLICK;
    end else begin
      ev_slot = key_slot;
      ev_act  = is_up ? ksc_pkg::ACT_UP : ksc_pkg::ACT_DOWN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_mask     <= '0;
      events.valid <= 1'b0;
    end else begin
      if (rec_pop) begin
        cur_mask <= {rec_enc_evt, rec_click, rec_key_evt};
      end else if (emit) begin
        cur_mask <= rem;
      end
      if (emit) begin
        events.valid <= 1'b1;
      end else if (events.ready) begin
        events.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rec_pop) begin
      cur_up  <= rec_key_up;
      cur_act <= rec_enc_act;
    end
    if (emit) begin
      events.event_slot   <= ev_slot;
      events.event_action <= ev_act;
      events.event_value  <= (ev_act != ksc_pkg::ACT_UP);
      events.last_of_pass <= (rem == '0);
    end
  end

endmodule

FILE: sv/key_and_knob_event_scanner.sv
// Top level of the key and knob event scanner.
// A sample's events pass through the record queue and the serializer's output registers.
// Throughput: one sample request per cycle while the four-entry record queue has room;
// the output serializer sends one event per cycle while the event receiver is ready.
// A sample that causes no event uses no queue entry and puts nothing on the event channel.
// Reset (rst, synchronous): all keys released, counters and accumulator zero, lockout 10.
module key_and_knob_event_scanner #(
  parameter int NUM_KEYS    = 6,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_data,
  ksc_sample_if.sink  samples,
  ksc_event_if.source events
);

  localparam int REC_W = 2 * NUM_KEYS + 2 + ksc_pkg::ACT_W;

  ksc_pkg::count_t     lockout_passes;
  logic                accept;
  logic                push;
  logic                full;
  logic                empty;
  logic                pop;
  logic [NUM_KEYS-1:0] f_key_evt;
  logic [NUM_KEYS-1:0] f_key_up;
  logic                f_click;
  logic                f_enc_evt;
  ksc_pkg::action_t    f_enc_act;
  logic [REC_W-1:0]    push_data;
  logic [REC_W-1:0]    pop_data;
  logic [NUM_KEYS-1:0] b_key_evt;
  logic [NUM_KEYS-1:0] b_key_up;
  logic                b_click;
  logic                b_enc_evt;
  ksc_pkg::action_t    b_enc_act;

  always_ff @(posedge clk) begin
    if (rst) begin
      lockout_passes <= ksc_pkg::LOCKOUT_RESET;
    end else if (cfg_we) begin
      lockout_passes <= cfg_data;
    end
  end

  assign samples.ready = !full;
  assign accept        = samples.valid && !full;

  ksc_front #(.NUM_KEYS(NUM_KEYS)) u_front (
    .clk              (clk),
    .rst              (rst),
    .accept           (accept),
    .key_levels       (samples.key_levels),
    .knob_switch_level(samples.knob_switch_level),
    .quad_a           (samples.quad_a),
    .quad_b           (samples.quad_b),
    .lockout_passes   (lockout_passes),
    .push             (push),
    .key_evt          (f_key_evt),
    .key_up           (f_key_up),
    .click            (f_click),
    .enc_evt          (f_enc_evt),
    .enc_act          (f_enc_act)
  );

  assign push_data = {f_enc_act, f_enc_evt, f_click, f_key_up, f_key_evt};
  assign {b_enc_act, b_enc_evt, b_click, b_key_up, b_key_evt} = pop_data;

  ksc_queue #(.WIDTH(REC_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_data),
    .full     (full),
    .pop      (pop),
    .pop_data (pop_data),
    .empty    (empty)
  );

  ksc_back #(.NUM_KEYS(NUM_KEYS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .rec_avail  (!empty),
    .rec_key_evt(b_key_evt),
    .rec_key_up (b_key_up),
    .rec_click  (b_click),
    .rec_enc_evt(b_enc_evt),
    .rec_enc_act(b_enc_act),
    .rec_pop    (pop),
    .events     (events)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("Record queue written while full.");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("Record queue read while empty.");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    events.valid |-> events.event_slot <= ksc_pkg::SLOT_PUSH_CW)
    else $error("Event slot out of range.");

  a_push_has_event: assert property (@(posedge clk) disable iff (rst)
    push |-> ((|f_key_evt) || f_click || f_enc_evt))
    else $error("Empty record pushed.");

endmodule

FILE: verif/key_and_knob_event_scanner_tb.sv
// Self-checking testbench for the key and knob event scanner with its own event predictor.
module key_and_knob_event_scanner_tb;

  localparam int TIMEOUT_CYCLES = 200000;
  localparam int SETTLE_CYCLES  = 12;
  localparam int SW_LOCK        = ksc_pkg::KEY_LEVEL_W;

  typedef struct packed {
    ksc_pkg::slot_t   slot;
    ksc_pkg::action_t action;
    logic             value;
    logic             last;
  } scan_event_t;

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_e;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [7:0] cfg_data;

  ksc_sample_if smp ();
  ksc_event_if  evt ();

  key_and_knob_event_scanner DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .samples  (smp),
    .events   (evt)
  );

  logic [ksc_pkg::KEY_LEVEL_W-1:0] mdl_keys;
  ksc_pkg::count_t                 mdl_lock [0:SW_LOCK];
  logic                            mdl_held;
  logic                            mdl_turned;
  ksc_pkg::quad_t                  mdl_quad;
  ksc_pkg::accum_t                 mdl_accum;
  ksc_pkg::count_t                 mdl_lockout;

  scan_event_t pending_events[$];
  int          mismatches = 0;
  int          cycle_count = 0;
  int          hold_off_cycles = 0;
  rx_mode_e    rx_mode = RX_ALWAYS;
  int          rx_phase = 0;
  bit          sender_gaps = 0;
  int          burst_left = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > TIMEOUT_CYCLES) begin
      $display("** key_and_knob_event_scanner: FAILED **");
      $finish;
    end
  end

  // The receiver follows the selected ready mode; a requested hold-off overrides it.
  initial begin
    evt.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_cycles > 0) begin
        evt.ready = 1'b0;
        hold_off_cycles = hold_off_cycles - 1;
      end else begin
        case (rx_mode)
          RX_ALWAYS: evt.ready = 1'b1;
          RX_RANDOM: evt.ready = ($urandom_range(0, 99) < 65);
          default: begin
            evt.ready = (rx_phase % 7) < 4;
            rx_phase = rx_phase + 1;
          end
        endcase
      end
    end
  end

  always @(posedge clk) begin : event_check
    scan_event_t want;
    scan_event_t got;
    if (!rst && evt.valid && evt.ready) begin
      got = '{evt.event_slot, evt.event_action, evt.event_value, evt.last_of_pass};
      if (pending_events.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= 10)
          $display("unexpected event: slot %0d action %0d value %0b last %0b",
                   got.slot, got.action, got.value, got.last);
      end else begin
        want = pending_events.pop_front();
        if (got.slot != want.slot || got.action != want.action ||
            got.value != want.value || got.last != want.last) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("event mismatch: expected slot %0d action %0d value %0b last %0b, %s",
                     want.slot, want.action, want.value, want.last,
                     $sformatf("got slot %0d action %0d value %0b last %0b",
                               got.slot, got.action, got.value, got.last));
        end
      end
    end
  end

  // Position of a quadrature state along the clockwise Gray sequence.
  function automatic logic [1:0] quad_pos(input ksc_pkg::quad_t q);
    return {q[0], q[1] ^ q[0]};
  endfunction

  function automatic ksc_pkg::quad_t quad_step(input ksc_pkg::quad_t q, input int dir);
    logic [1:0] p;
    p = quad_pos(q) + dir[1:0];
    return {p[0] ^ p[1], p[1]};
  endfunction

  function automatic scan_event_t make_event(input ksc_pkg::slot_t s,
                                             input ksc_pkg::action_t a);
    return '{s, a, (a != ksc_pkg::ACT_UP), 1'b0};
  endfunction

  function automatic void reset_model();
    mdl_keys    = '1;
    for (int i = 0; i <= SW_LOCK; i++) mdl_lock[i] = '0;
    mdl_held    = 1'b0;
    mdl_turned  = 1'b0;
    mdl_quad    = ksc_pkg::QUAD_REST;
    mdl_accum   = '0;
    mdl_lockout = ksc_pkg::LOCKOUT_RESET;
  endfunction

  function automatic void predict_pass(input logic [ksc_pkg::KEY_LEVEL_W-1:0] lv,
                                       input logic sw, input ksc_pkg::quad_t ab);
    scan_event_t evs[$];
    logic [1:0]  dpos;
    for (int i = 0; i < ksc_pkg::KEY_LEVEL_W; i++) begin
      if (mdl_lock[i] != 0) begin
        mdl_lock[i] = mdl_lock[i] - 1'b1;
      end else if (lv[i] != mdl_keys[i]) begin
        mdl_lock[i] = mdl_lockout;
        evs.push_back(make_event(ksc_pkg::slot_t'(i),
                                 lv[i] ? ksc_pkg::ACT_UP : ksc_pkg::ACT_DOWN));
        mdl_keys[i] = lv[i];
      end
    end
    if (mdl_lock[SW_LOCK] != 0) begin
      mdl_lock[SW_LOCK] = mdl_lock[SW_LOCK] - 1'b1;
    end else if (!sw && !mdl_held) begin
      mdl_held = 1'b1;
      mdl_turned = 1'b0;
      mdl_lock[SW_LOCK] = mdl_lockout;
    end else if (sw && mdl_held) begin
      mdl_held = 1'b0;
      mdl_lock[SW_LOCK] = mdl_lockout;
      if (!mdl_turned) evs.push_back(make_event(ksc_pkg::SLOT_CLICK, ksc_pkg::ACT_CLICK));
    end
    if (ab != mdl_quad) begin
      dpos = quad_pos(ab) - quad_pos(mdl_quad);
      if (dpos == 2'd1) mdl_accum = mdl_accum + 8'd1;
      else if (dpos == 2'd3) mdl_accum = mdl_accum - 8'd1;
      mdl_quad = ab;
      if (ab == ksc_pkg::QUAD_REST && mdl_accum != '0) begin
        if (mdl_held) begin
          mdl_turned = 1'b1;
          if (mdl_accum[ksc_pkg::ACC_W-1])
            evs.push_back(make_event(ksc_pkg::SLOT_PUSH_CCW, ksc_pkg::ACT_PUSH_CCW));
          else evs.push_back(make_event(ksc_pkg::SLOT_PUSH_CW, ksc_pkg::ACT_PUSH_CW));
        end else begin
          if (mdl_accum[ksc_pkg::ACC_W-1])
            evs.push_back(make_event(ksc_pkg::SLOT_CCW, ksc_pkg::ACT_CCW));
          else evs.push_back(make_event(ksc_pkg::SLOT_CW, ksc_pkg::ACT_CW));
        end
        mdl_accum = '0;
      end
    end
    if (evs.size() > 0) evs[evs.size()-1].last = 1'b1;
    foreach (evs[k]) pending_events.push_back(evs[k]);
  endfunction

  task automatic send_sample(input logic [ksc_pkg::KEY_LEVEL_W-1:0] lv, input logic sw,
                             input ksc_pkg::quad_t q);
    int gap;
    smp.valid = 1'b1;
    smp.key_levels = lv;
    smp.knob_switch_level = sw;
    smp.quad_a = q[1];
    smp.quad_b = q[0];
    do @(posedge clk); while (!smp.ready);
    predict_pass(lv, sw, q);
    @(negedge clk);
    smp.valid = 1'b0;
    if (sender_gaps) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 8);
        repeat (gap) @(negedge clk);
        burst_left = $urandom_range(1, 12);
      end else begin
        burst_left = burst_left - 1;
      end
    end
  endtask

  task automatic wait_idle();
    smp.valid = 1'b0;
    while (pending_events.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_lockout(input ksc_pkg::count_t passes);
    wait_idle();
    cfg_we = 1'b1;
    cfg_data = passes;
    @(negedge clk);
    cfg_we = 1'b0;
    mdl_lockout = passes;
  endtask

  task automatic test_key_edges();
    rx_mode = RX_ALWAYS;
    sender_gaps = 0;
    write_lockout(8'd0);
    send_sample(6'h00, 1'b1, ksc_pkg::QUAD_REST);
    send_sample(6'h3F, 1'b1, ksc_pkg::QUAD_REST);
    send_sample(6'h15, 1'b1, ksc_pkg::QUAD_REST);
    send_sample(6'h2A, 1'b1, ksc_pkg::QUAD_REST);
    send_sample(6'h3F, 1'b1, ksc_pkg::QUAD_REST);
  endtask

  task automatic test_lockout_hold();
    write_lockout(8'd2);
    send_sample(6'h3E, 1'b1, ksc_pkg::QUAD_REST);
    send_sample(6'h3F, 1'b1, ksc_pkg::QUAD_REST);
    send_sample(6'h3F, 1'b1, ksc_pkg::QUAD_REST);
    send_sample(6'h3F, 1'b1, ksc_pkg::QUAD_REST);
  endtask

  task automatic test_knob();
    write_lockout(8'd0);
    send_sample(6'h3F, 1'b0, ksc_pkg::QUAD_REST);
    send_sample(6'h3F, 1'b1, ksc_pkg::QUAD_REST);
    send_sample(6'h3F, 1'b0, ksc_pkg::QUAD_REST);
    send_sample(6'h3F, 1'b0, 2'b01);
    send_sample(6'h3F, 1'b0, 2'b00);
    send_sample(6'h3F, 1'b0, 2'b10);
    send_sample(6'h3F, 1'b0, 2'b11);
    send_sample(6'h3F, 1'b1, 2'b11);
    send_sample(6'h3F, 1'b1, 2'b10);
    send_sample(6'h3F, 1'b1, 2'b00);
    send_sample(6'h3F, 1'b1, 2'b01);
    send_sample(6'h3F, 1'b1, 2'b11);
    send_sample(6'h3F, 1'b1, 2'b00);
    send_sample(6'h3F, 1'b1, 2'b11);
  endtask

  // The switch release is seen in the same pass as the return to rest.
  task automatic test_turn_during_switch_lockout();
    write_lockout(8'd3);
    send_sample(6'h3F, 1'b0, ksc_pkg::QUAD_REST);
    send_sample(6'h3F, 1'b1, 2'b10);
    send_sample(6'h3F, 1'b1, 2'b00);
    send_sample(6'h3F, 1'b1, 2'b01);
    send_sample(6'h3F, 1'b1, 2'b11);
  endtask

  task automatic test_backpressure();
    write_lockout(8'd0);
    rx_mode = RX_ALWAYS;
    sender_gaps = 0;
    hold_off_cycles = 250;
    for (int i = 0; i < 24; i++)
      send_sample((i % 2 == 0) ? 6'h00 : 6'h3F, 1'b1, ksc_pkg::QUAD_REST);
    wait_idle();
  endtask

  task automatic test_random_traffic(input int n, input ksc_pkg::count_t passes,
                                     input rx_mode_e mode, input bit gaps);
    logic [ksc_pkg::KEY_LEVEL_W-1:0] keys;
    logic                            sw;
    ksc_pkg::quad_t                  q;
    int                              dir;
    logic [31:0]                     r;
    write_lockout(passes);
    rx_mode = mode;
    sender_gaps = gaps;
    keys = mdl_keys;
    sw = !mdl_held;
    q = mdl_quad;
    dir = 1;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 8) begin
        r = $urandom;
        keys = r[ksc_pkg::KEY_LEVEL_W-1:0];
        sw = r[8];
        q = r[17:16];
      end else begin
        if ($urandom_range(0, 2) == 0)
          keys[$urandom_range(0, ksc_pkg::KEY_LEVEL_W-1)] ^= 1'b1;
        if ($urandom_range(0, 5) == 0)
          keys[$urandom_range(0, ksc_pkg::KEY_LEVEL_W-1)] ^= 1'b1;
        if ($urandom_range(0, 5) == 0) sw = ~sw;
        if ($urandom_range(0, 15) == 0) dir = -dir;
        case ($urandom_range(0, 3))
          0: q = q;
          3: q = quad_step(q, -dir);
          default: q = quad_step(q, dir);
        endcase
      end
      send_sample(keys, sw, q);
    end
  endtask

  // Net 128 steps without passing rest, so the accumulator wraps to negative.
  task automatic test_accumulator_wrap();
    logic [ksc_pkg::KEY_LEVEL_W-1:0] keys;
    logic                            sw;
    logic [31:0]                     r;
    write_lockout(8'd1);
    rx_mode = RX_ALWAYS;
    sender_gaps = 0;
    keys = 6'h3F;
    r = $urandom;
    sw = r[0];
    send_sample(keys, sw, ksc_pkg::QUAD_REST);
    send_sample(keys, sw, 2'b01);
    for (int i = 0; i < 64; i++) begin
      if ($urandom_range(0, 3) == 0) keys[$urandom_range(0, ksc_pkg::KEY_LEVEL_W-1)] ^= 1'b1;
      send_sample(keys, sw, 2'b00);
      send_sample(keys, sw, 2'b10);
      send_sample(keys, sw, 2'b01);
    end
    send_sample(keys, sw, ksc_pkg::QUAD_REST);
  endtask

  task automatic test_lockout_extremes();
    write_lockout(8'd255);
    rx_mode = RX_RANDOM;
    sender_gaps = 1;
    send_sample(6'h00, 1'b0, ksc_pkg::QUAD_REST);
    send_sample(6'h3F, 1'b1, 2'b01);
    send_sample(6'h3F, 1'b1, 2'b00);
    send_sample(6'h3F, 1'b1, 2'b10);
    send_sample(6'h3F, 1'b1, ksc_pkg::QUAD_REST);
    send_sample(6'h00, 1'b0, ksc_pkg::QUAD_REST);
    write_lockout(ksc_pkg::LOCKOUT_RESET);
  endtask

  task automatic finish_run();
    wait_idle();
    if (mismatches == 0 && pending_events.size() == 0) begin
      $display("** key_and_knob_event_scanner: PASSED **");
    end else begin
      $display("** key_and_knob_event_scanner: FAILED **");
    end
    $finish;
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    smp.valid = 1'b0;
    smp.key_levels = '1;
    smp.knob_switch_level = 1'b1;
    smp.quad_a = 1'b1;
    smp.quad_b = 1'b1;
    reset_model();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_key_edges();
    test_lockout_hold();
    test_knob();
    test_turn_during_switch_lockout();
    test_backpressure();
    test_random_traffic(40, ksc_pkg::LOCKOUT_RESET, RX_RANDOM, 1);
    test_random_traffic(40, 8'd0, RX_PATTERN, 1);
    test_accumulator_wrap();
    test_random_traffic(40, ksc_pkg::count_t'($urandom_range(2, 5)), RX_RANDOM, 1);
    test_lockout_extremes();
    finish_run();
  end

endmodule

FILE: filelist.f
sv/ksc_pkg.sv
sv/ksc_ifs.sv
sv/ksc_front.sv
sv/ksc_queue.sv
sv/ksc_back.sv
sv/key_and_knob_event_scanner.sv
verif/key_and_knob_event_scanner_tb.sv
